// ===== design/aes256_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-256 package
// S-box table, round constants and round helper functions.
// ----------------------------------------------------------------------------
package aes256_pkg;

  localparam int unsigned NumRounds = 14;

  typedef logic [127:0] state_t;
  typedef logic [255:0] key_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd1: r = 8'h01;
      3'd2: r = 8'h02;
      3'd3: r = 8'h04;
      3'd4: r = 8'h08;
      3'd5: r = 8'h10;
      3'd6: r = 8'h20;
      3'd7: r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte k of the state sits at bits [127-8k -: 8], column c holds bytes 4c..4c+3.
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic state_t mix_columns(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

// ===== design/aes256_if.sv =====
// ----------------------------------------------------------------------------
// AES-256 stream interfaces
// Valid/ready channels for key plus plaintext in and ciphertext out.
// ----------------------------------------------------------------------------
interface aes256_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_part_0;
  logic [63:0] key_part_1;
  logic [63:0] key_part_2;
  logic [63:0] key_part_3;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, key_part_0, key_part_1, key_part_2, key_part_3,
                  plain_high, plain_low, input ready);
  modport sink (input valid, key_part_0, key_part_1, key_part_2, key_part_3,
                plain_high, plain_low, output ready);
endinterface

interface aes256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

// ===== design/aes256_round.sv =====
// ----------------------------------------------------------------------------
// AES-256 round stage
// One pipeline stage: one cipher round plus the next half step of the key
// schedule, registered, with its valid bit and a stall enable.
// ----------------------------------------------------------------------------
module aes256_round #(
  parameter int unsigned Round = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  aes256_pkg::state_t state_i,
  input  aes256_pkg::key_t   key_i,
  output logic               valid_o,
  output aes256_pkg::state_t state_o,
  output aes256_pkg::key_t   key_o
);

  aes256_pkg::state_t st_d, st_q;
  aes256_pkg::key_t   key_d, key_q;
  logic               valid_q;
  logic [31:0]        t, w4, w5, w6, w7;

  // The key window holds schedule words 4(Round-1)..4(Round-1)+7; slide by four.
  always_comb begin
    if ((Round % 2) == 1) begin
      t = aes256_pkg::sub_word({key_i[23:0], key_i[31:24]}) ^
          {aes256_pkg::rcon(3'((Round + 1) / 2)), 24'h0};
    end else begin
      t = aes256_pkg::sub_word(key_i[31:0]);
    end
    w4 = key_i[255:224] ^ t;
    w5 = key_i[223:192] ^ w4;
    w6 = key_i[191:160] ^ w5;
    w7 = key_i[159:128] ^ w6;
    key_d = {key_i[127:0], w4, w5, w6, w7};
    if (Round == aes256_pkg::NumRounds) begin
      st_d = aes256_pkg::sub_shift(state_i) ^ key_i[127:0];
    end else begin
      st_d = aes256_pkg::mix_columns(aes256_pkg::sub_shift(state_i)) ^ key_i[127:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      key_q <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = st_q;
  assign key_o   = key_q;

endmodule

// ===== design/aes256_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES-256 block encryption
// Fully pipelined FIPS-197 AES-256 encryption with on-the-fly key expansion.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle unless the pipeline holds. The pipeline has
// fifteen register stages: the initial key addition, then one stage per round,
// each round stage computing SubBytes, ShiftRows, MixColumns (not in the last
// round) and AddRoundKey while it derives the next four key words. The whole
// pipeline advances together and holds when the last stage has a result that
// the sink does not take.
module aes256_block_encrypt (
  input logic        clk_i,
  input logic        rst_ni,
  aes256_in_if.sink  in_i,
  aes256_out_if.source out_o
);

  localparam int unsigned N = aes256_pkg::NumRounds;

  logic               valid_s [N+1];
  aes256_pkg::state_t state_s [N+1];
  aes256_pkg::key_t   key_s   [N+1];
  logic               en;
  logic               valid0_q;
  aes256_pkg::state_t state0_q;
  aes256_pkg::key_t   key0_q;

  assign en       = !valid_s[N] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (en) begin
      valid0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      key0_q   <= {in_i.key_part_0, in_i.key_part_1, in_i.key_part_2, in_i.key_part_3};
      state0_q <= {in_i.plain_high, in_i.plain_low} ^ {in_i.key_part_0, in_i.key_part_1};
    end
  end

  assign valid_s[0] = valid0_q;
  assign state_s[0] = state0_q;
  assign key_s[0]   = key0_q;

  for (genvar r = 1; r <= N; r++) begin : g_round
    aes256_round #(.Round(r)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[r-1]),
      .state_i (state_s[r-1]),
      .key_i   (key_s[r-1]),
      .valid_o (valid_s[r]),
      .state_o (state_s[r]),
      .key_o   (key_s[r])
    );
  end

  assign out_o.valid       = valid_s[N];
  assign out_o.cipher_high = state_s[N][127:64];
  assign out_o.cipher_low  = state_s[N][63:0];

endmodule
